>>> hdl/prot3_pkg.sv
// Shared constants, types and the arctangent table for the three-axis point rotator.
package prot3_pkg;

  localparam int unsigned ATAN_ENTRIES  = 30;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned GUARD_BITS    = 4;
  localparam int unsigned ANG_REG_BITS  = 16;
  localparam int unsigned ANGLE_BITS    = 32;
  localparam logic [31:0] GAIN_Q32      = 32'd2608131496;
  localparam int unsigned GAIN_SPLIT    = 24;
  localparam int unsigned GAIN_LAT      = 4;
  localparam int unsigned ROUND_LAT     = 3;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ANGLE_X      = 3'd0,
    REG_ANGLE_Y      = 3'd1,
    REG_ANGLE_Z      = 3'd2,
    REG_RIGHT_HANDED = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic skip;
  } cell_ctl_t;

  // Arctangent of 2^-idx with a half turn equal to 2^31.
  function automatic logic [ANGLE_BITS-1:0] atan_entry(input int unsigned idx);
    logic [ANGLE_BITS-1:0] r;
    case (idx)
      0:       r = 32'h20000000;
      1:       r = 32'h12E4051E;
      2:       r = 32'h09FB385B;
      3:       r = 32'h051111D4;
      4:       r = 32'h028B0D43;
      5:       r = 32'h0145D7E1;
      6:       r = 32'h00A2F61E;
      7:       r = 32'h00517C55;
      8:       r = 32'h0028BE53;
      9:       r = 32'h00145F2F;
      10:      r = 32'h000A2F98;
      11:      r = 32'h000517CC;
      12:      r = 32'h00028BE6;
      13:      r = 32'h000145F3;
      14:      r = 32'h0000A2FA;
      15:      r = 32'h0000517D;
      16:      r = 32'h000028BE;
      17:      r = 32'h0000145F;
      18:      r = 32'h00000A30;
      19:      r = 32'h00000518;
      20:      r = 32'h0000028C;
      21:      r = 32'h00000146;
      22:      r = 32'h000000A3;
      23:      r = 32'h00000051;
      24:      r = 32'h00000029;
      25:      r = 32'h00000014;
      26:      r = 32'h0000000A;
      27:      r = 32'h00000005;
      28:      r = 32'h00000003;
      29:      r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/prot3_cell.sv
// One CORDIC micro-rotation cell: turns a coordinate pair by plus or minus atan(2^-IDX).
module prot3_cell import prot3_pkg::*; #(
  parameter int unsigned W   = 36,
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_ctl_t                    ctl_i,
  input  logic signed [W-1:0]          u_i,
  input  logic signed [W-1:0]          v_i,
  input  logic signed [W-1:0]          w_i,
  input  logic signed [ANGLE_BITS-1:0] a_i,
  output cell_ctl_t                    ctl_o,
  output logic signed [W-1:0]          u_o,
  output logic signed [W-1:0]          v_o,
  output logic signed [W-1:0]          w_o,
  output logic signed [ANGLE_BITS-1:0] a_o
);

  localparam logic signed [ANGLE_BITS-1:0] STEP = atan_entry(IDX);

  cell_ctl_t                    ctl_q;
  logic signed [W-1:0]          u_d, u_q, v_d, v_q, w_q;
  logic signed [ANGLE_BITS-1:0] a_d, a_q;
  logic signed [W-1:0]          du, dv;

  assign du = v_i >>> IDX;
  assign dv = u_i >>> IDX;

  // A skipped turn carries its pair through untouched.
  always_comb begin
    if (ctl_i.skip) begin
      u_d = u_i;
      v_d = v_i;
      a_d = a_i;
    end else if (!a_i[ANGLE_BITS-1]) begin
      u_d = u_i - du;
      v_d = v_i + dv;
      a_d = a_i - STEP;
    end else begin
      u_d = u_i + du;
      v_d = v_i - dv;
      a_d = a_i + STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    w_q <= w_i;
    a_q <= a_d;
  end

  assign ctl_o = ctl_q;
  assign u_o   = u_q;
  assign v_o   = v_q;
  assign w_o   = w_q;
  assign a_o   = a_q;

endmodule

>>> hdl/prot3_gain.sv
// Four-stage gain compensation: scales one coordinate by the inverse CORDIC gain, rounded, unless skip_i is set.
module prot3_gain import prot3_pkg::*; #(
  parameter int unsigned W = 36
) (
  input  logic                clk_i,
  input  logic                skip_i,
  input  logic signed [W-1:0] v_i,
  output logic signed [W-1:0] v_o
);

  localparam int unsigned MW = W - 1;
  localparam int unsigned HW = MW - GAIN_SPLIT;
  localparam int unsigned LW = GAIN_SPLIT + 32;
  localparam int unsigned PW = HW + 32;
  localparam int unsigned SW = HW + GAIN_SPLIT + 32 + 1;
  localparam logic [SW-1:0] HALF_LSB = SW'(1) << 31;

  logic signed [W-1:0] neg_v, pos2;
  logic [MW-1:0]       mag0_q, mag1_q, mag2_q;
  logic                sign0_q, sign1_q, sign2_q, skip0_q, skip1_q;
  logic [LW-1:0]       plo_q;
  logic [PW-1:0]       phi_q;
  logic [SW-1:0]       sum;
  logic signed [W-1:0] v_q;

  assign neg_v = -v_i;
  assign sum   = SW'({phi_q, {GAIN_SPLIT{1'b0}}}) + SW'(plo_q) + HALF_LSB;
  assign pos2  = {1'b0, mag2_q};

  // Magnitude, split product, round to nearest, then the sign goes back on.
  always_ff @(posedge clk_i) begin
    sign0_q <= v_i[W-1];
    skip0_q <= skip_i;
    mag0_q  <= v_i[W-1] ? neg_v[MW-1:0] : v_i[MW-1:0];

    plo_q   <= LW'(mag0_q[GAIN_SPLIT-1:0]) * LW'(GAIN_Q32);
    phi_q   <= PW'(mag0_q[MW-1:GAIN_SPLIT]) * PW'(GAIN_Q32);
    mag1_q  <= mag0_q;
    sign1_q <= sign0_q;
    skip1_q <= skip0_q;

    mag2_q  <= skip1_q ? mag1_q : sum[32 +: MW];
    sign2_q <= sign1_q;

    v_q     <= sign2_q ? -pos2 : pos2;
  end

  assign v_o = v_q;

endmodule

>>> hdl/prot3_turn.sv
// One plane turn: quadrant fold, a chain of CORDIC cells and gain compensation of the pair.
module prot3_turn import prot3_pkg::*; #(
  parameter int unsigned W      = 36,
  parameter int unsigned STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [W-1:0]           u_i,
  input  logic signed [W-1:0]           v_i,
  input  logic signed [W-1:0]           w_i,
  input  logic signed [ANG_REG_BITS:0]  ang_i,
  output logic                          valid_o,
  output logic signed [W-1:0]           u_o,
  output logic signed [W-1:0]           v_o,
  output logic signed [W-1:0]           w_o
);

  localparam logic signed [ANG_REG_BITS:0] QUARTER =
    (ANG_REG_BITS + 1)'(1) << (ANG_REG_BITS - 2);
  localparam logic signed [ANG_REG_BITS:0] HALF =
    (ANG_REG_BITS + 1)'(1) << (ANG_REG_BITS - 1);

  logic signed [ANG_REG_BITS:0]  ang_f;
  logic                          flip;
  logic signed [ANGLE_BITS-1:0]  a_f;

  cell_ctl_t                     c_ctl [STAGES+1];
  logic signed [W-1:0]           c_u   [STAGES+1];
  logic signed [W-1:0]           c_v   [STAGES+1];
  logic signed [W-1:0]           c_w   [STAGES+1];
  logic signed [ANGLE_BITS-1:0]  c_a   [STAGES+1];

  cell_ctl_t                     f_ctl_q;
  logic signed [W-1:0]           f_u_q, f_v_q, f_w_q;
  logic signed [ANGLE_BITS-1:0]  f_a_q;

  logic                          dl_valid_q [GAIN_LAT];
  logic signed [W-1:0]           dl_w_q     [GAIN_LAT];

  // Angles past a quarter turn become a half turn (negated pair) plus the rest.
  always_comb begin
    flip  = 1'b0;
    ang_f = ang_i;
    if (ang_i > QUARTER) begin
      flip  = 1'b1;
      ang_f = ang_i - HALF;
    end else if (ang_i < -QUARTER) begin
      flip  = 1'b1;
      ang_f = ang_i + HALF;
    end
  end

  assign a_f = {ang_f[ANG_REG_BITS-1:0], {(ANGLE_BITS - ANG_REG_BITS){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_ctl_q <= '0;
    end else begin
      f_ctl_q.valid <= valid_i;
      f_ctl_q.skip  <= (ang_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    f_u_q <= flip ? -u_i : u_i;
    f_v_q <= flip ? -v_i : v_i;
    f_w_q <= w_i;
    f_a_q <= a_f;
  end

  assign c_ctl[0] = f_ctl_q;
  assign c_u[0]   = f_u_q;
  assign c_v[0]   = f_v_q;
  assign c_w[0]   = f_w_q;
  assign c_a[0]   = f_a_q;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    prot3_cell #(
      .W   (W),
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (c_ctl[i]),
      .u_i    (c_u[i]),
      .v_i    (c_v[i]),
      .w_i    (c_w[i]),
      .a_i    (c_a[i]),
      .ctl_o  (c_ctl[i+1]),
      .u_o    (c_u[i+1]),
      .v_o    (c_v[i+1]),
      .w_o    (c_w[i+1]),
      .a_o    (c_a[i+1])
    );
  end

  prot3_gain #(.W(W)) u_gain_u (
    .clk_i  (clk_i),
    .skip_i (c_ctl[STAGES].skip),
    .v_i    (c_u[STAGES]),
    .v_o    (u_o)
  );

  prot3_gain #(.W(W)) u_gain_v (
    .clk_i  (clk_i),
    .skip_i (c_ctl[STAGES].skip),
    .v_i    (c_v[STAGES]),
    .v_o    (v_o)
  );

  // The third coordinate and the valid flag wait out the gain pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < GAIN_LAT; k++) begin
        dl_valid_q[k] <= 1'b0;
      end
    end else begin
      dl_valid_q[0] <= c_ctl[STAGES].valid;
      for (int k = 1; k < GAIN_LAT; k++) begin
        dl_valid_q[k] <= dl_valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_w_q[0] <= c_w[STAGES];
    for (int k = 1; k < GAIN_LAT; k++) begin
      dl_w_q[k] <= dl_w_q[k-1];
    end
  end

  assign valid_o = dl_valid_q[GAIN_LAT-1];
  assign w_o     = dl_w_q[GAIN_LAT-1];

endmodule

>>> hdl/point_rotation_three_axis.sv
// Three-axis point rotator: x, then y, then z plane turns, rounding and saturation.
// Each of the three turns is one fold stage, one CORDIC cell per stage and a four-stage gain
// multiplier, and three rounding stages follow. One point is accepted every cycle and busy_o
// stays low. The receiver cannot stall; done_o marks each result word for exactly one cycle.
// Reset clears the pipeline, sets all three angles to zero and selects the right-handed frame.
module point_rotation_three_axis import prot3_pkg::*; #(
  parameter int unsigned COORD_BITS      = 16,
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [COORD_BITS-1:0]    pos_x_i,
  input  logic signed [COORD_BITS-1:0]    pos_y_i,
  input  logic signed [COORD_BITS-1:0]    pos_z_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data_i,
  output logic                            done_o,
  output logic signed [COORD_BITS-1:0]    new_x_o,
  output logic signed [COORD_BITS-1:0]    new_y_o,
  output logic signed [COORD_BITS-1:0]    new_z_o,
  output logic                            clipped_o
);

  // The table holds thirty arctangents, so longer chains are capped there.
  localparam int unsigned N_STAGES =
    (ROTATION_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : ROTATION_STAGES;
  // Working coordinates carry 16 fraction bits and a few guard bits for CORDIC growth.
  localparam int unsigned W        = COORD_BITS + FRAC_BITS + GUARD_BITS;
  localparam int unsigned RW       = W - FRAC_BITS;
  localparam int unsigned LATENCY  = 3 * (1 + N_STAGES + GAIN_LAT) + ROUND_LAT;
  localparam int unsigned CNT_BITS = $clog2(LATENCY + 1);
  localparam logic [RW-1:0] NEG_LIM = RW'(1) << (COORD_BITS - 1);
  localparam logic [RW-1:0] POS_LIM = NEG_LIM - RW'(1);

  // Configuration registers. They are only rewritten with the pipeline empty, so every
  // turn reads them directly as the word passes by.
  logic [ANG_REG_BITS-1:0]      ang_x_q, ang_y_q, ang_z_q;
  logic                         right_handed_q;
  logic signed [ANG_REG_BITS:0] ang_x_s, ang_y_s, ang_z_s;
  logic signed [ANG_REG_BITS:0] eff_x, eff_y, eff_z;
  logic                         cfg_we;

  // Count of words in flight; a configuration write waits until it is zero.
  logic [CNT_BITS-1:0]          cnt_d, cnt_q;
  logic                         accept;

  logic signed [W-1:0]          x0, y0, z0;
  logic                         t1_valid, t2_valid, t3_valid;
  logic signed [W-1:0]          t1_u, t1_v, t1_w;
  logic signed [W-1:0]          t2_u, t2_v, t2_w;
  logic signed [W-1:0]          t3_u, t3_v, t3_w;

  logic signed [W-1:0]          fin      [3];
  logic [COORD_BITS-1:0]        lane_res [3];
  logic                         lane_clip[3];
  logic [ROUND_LAT-1:0]         rv_q;

  // The pipeline never refuses a point.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign cfg_ready_o = (cnt_q == '0) && !start_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q        <= '0;
      ang_y_q        <= '0;
      ang_z_q        <= '0;
      right_handed_q <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ANGLE_X:      ang_x_q        <= cfg_data_i[ANG_REG_BITS-1:0];
        REG_ANGLE_Y:      ang_y_q        <= cfg_data_i[ANG_REG_BITS-1:0];
        REG_ANGLE_Z:      ang_z_q        <= cfg_data_i[ANG_REG_BITS-1:0];
        REG_RIGHT_HANDED: right_handed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // In the left-handed frame every angle is negated; the most negative angle then becomes
  // a positive half turn, which is why the effective angle has one extra bit.
  assign ang_x_s = {ang_x_q[ANG_REG_BITS-1], ang_x_q};
  assign ang_y_s = {ang_y_q[ANG_REG_BITS-1], ang_y_q};
  assign ang_z_s = {ang_z_q[ANG_REG_BITS-1], ang_z_q};
  assign eff_x   = right_handed_q ? ang_x_s : -ang_x_s;
  assign eff_y   = right_handed_q ? ang_y_s : -ang_y_s;
  assign eff_z   = right_handed_q ? ang_z_s : -ang_z_s;

  always_comb begin
    cnt_d = cnt_q + CNT_BITS'(accept) - CNT_BITS'(done_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Points enter as fixed point with 16 fraction bits.
  assign x0 = {{(W - COORD_BITS - FRAC_BITS){pos_x_i[COORD_BITS-1]}}, pos_x_i,
               {FRAC_BITS{1'b0}}};
  assign y0 = {{(W - COORD_BITS - FRAC_BITS){pos_y_i[COORD_BITS-1]}}, pos_y_i,
               {FRAC_BITS{1'b0}}};
  assign z0 = {{(W - COORD_BITS - FRAC_BITS){pos_z_i[COORD_BITS-1]}}, pos_z_i,
               {FRAC_BITS{1'b0}}};

  // Turn about x works on the pair (y, z) and carries x along.
  prot3_turn #(.W(W), .STAGES(N_STAGES)) u_turn_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .u_i     (y0),
    .v_i     (z0),
    .w_i     (x0),
    .ang_i   (eff_x),
    .valid_o (t1_valid),
    .u_o     (t1_u),
    .v_o     (t1_v),
    .w_o     (t1_w)
  );

  // Turn about y works on the pair (z, x) and carries y along.
  prot3_turn #(.W(W), .STAGES(N_STAGES)) u_turn_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t1_valid),
    .u_i     (t1_v),
    .v_i     (t1_w),
    .w_i     (t1_u),
    .ang_i   (eff_y),
    .valid_o (t2_valid),
    .u_o     (t2_u),
    .v_o     (t2_v),
    .w_o     (t2_w)
  );

  // Turn about z works on the pair (x, y) and carries z along.
  prot3_turn #(.W(W), .STAGES(N_STAGES)) u_turn_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t2_valid),
    .u_i     (t2_v),
    .v_i     (t2_w),
    .w_i     (t2_u),
    .ang_i   (eff_z),
    .valid_o (t3_valid),
    .u_o     (t3_u),
    .v_o     (t3_v),
    .w_o     (t3_w)
  );

  assign fin[0] = t3_u;
  assign fin[1] = t3_v;
  assign fin[2] = t3_w;

  // Each lane rounds to nearest with ties away from zero, then saturates. Stage one takes
  // the magnitude, stage two adds the half LSB and drops the fraction, stage three clamps
  // and restores the sign into the output register.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [W-1:0]   neg_in;
    logic                  neg0_q, neg1_q;
    logic [W-2:0]          mag0_q;
    logic [W-1:0]          rsum;
    logic [RW-1:0]         rnd_q, rnd_neg;
    logic                  over;
    logic [COORD_BITS-1:0] out_q;
    logic                  clip_q;

    assign neg_in  = -fin[l];
    assign rsum    = {1'b0, mag0_q} + (W'(1) << (FRAC_BITS - 1));
    assign rnd_neg = -rnd_q;
    assign over    = neg1_q ? (rnd_q > NEG_LIM) : (rnd_q > POS_LIM);

    always_ff @(posedge clk_i) begin
      neg0_q <= fin[l][W-1];
      mag0_q <= fin[l][W-1] ? neg_in[W-2:0] : fin[l][W-2:0];

      neg1_q <= neg0_q;
      rnd_q  <= rsum[W-1:FRAC_BITS];

      clip_q <= over;
      if (over) begin
        out_q <= neg1_q ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
        out_q <= neg1_q ? rnd_neg[COORD_BITS-1:0] : rnd_q[COORD_BITS-1:0];
      end
    end

    assign lane_res[l]  = out_q;
    assign lane_clip[l] = clip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= '0;
    end else begin
      rv_q <= {rv_q[ROUND_LAT-2:0], t3_valid};
    end
  end

  assign done_o    = rv_q[ROUND_LAT-1];
  assign new_x_o   = lane_res[0];
  assign new_y_o   = lane_res[1];
  assign new_z_o   = lane_res[2];
  assign clipped_o = lane_clip[0] | lane_clip[1] | lane_clip[2];

  // Every accepted point comes out after exactly the pipeline latency.
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("point result did not appear after the pipeline latency");

  // A result is never produced without a point in flight.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cnt_q != '0))
    else $error("result strobe with no point in flight");

  // The pipeline never holds more points than it has stages.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(LATENCY))
    else $error("in-flight count exceeds pipeline depth");

endmodule

>>> verif/point_rotation_three_axis_test.sv
// Self-checking testbench for the three-axis point rotator with a scoreboard-based predictor.
module point_rotation_three_axis_test;
  import prot3_pkg::*;

  // The bench mirrors the default sizes of the block and passes them on explicitly.
  localparam int unsigned COORD_BITS      = 16;
  localparam int unsigned ROTATION_STAGES = 16;

  // The predictor never runs more stages than its arctangent table holds.
  localparam int unsigned TURN_STEPS   = (ROTATION_STAGES < 30) ? ROTATION_STAGES : 30;
  localparam int unsigned LATENCY      = 3 * ROTATION_STAGES + 18;
  localparam int unsigned DRAIN_LIMIT  = 20 * LATENCY + 1000;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned REPORT_LIMIT = 10;

  // Working coordinates carry 16 fraction bits; the working angle has a half turn of 2^31.
  localparam int unsigned   WORK_FRAC    = 16;
  localparam longint        QUARTER_Q31  = longint'(1) <<< 30;
  localparam longint        HALF_Q31     = longint'(1) <<< 31;
  localparam longint unsigned GAIN_INV_Q32 = 64'd2608131496;
  localparam longint        COORD_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint        COORD_MIN    = -COORD_MAX - 1;

  // Arctangent of 2^-i with a half turn equal to 2^31, rounded to nearest.
  localparam longint ATAN_Q31 [0:29] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  // Fixed run limit for the watchdog, in simulation time units.
  localparam longint RUN_LIMIT = 64'd4_000_000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         clipped;
  } rotated_point_t;

  // The scoreboard holds its own copy of the angle registers and the frame bit, computes
  // the rotated point for every accepted input word and compares each result word with
  // the oldest rotated point that is still waiting.
  class rotation_scoreboard;
    logic [15:0]    ang_x;
    logic [15:0]    ang_y;
    logic [15:0]    ang_z;
    logic           right_hand;
    rotated_point_t pending[$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    noted;

    function new();
      ang_x      = '0;
      ang_y      = '0;
      ang_z      = '0;
      right_hand = 1'b1;
      errors     = 0;
      checked    = 0;
      noted      = 0;
    endfunction

    // Indexes outside the register list are dropped, like the block does.
    function void write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_ANGLE_X:      ang_x = data[15:0];
        REG_ANGLE_Y:      ang_y = data[15:0];
        REG_ANGLE_Z:      ang_z = data[15:0];
        REG_RIGHT_HANDED: right_hand = data[0];
        default: ;
      endcase
    endfunction

    // Gain compensation on the magnitude, split so that no product overflows 64 bits.
    function longint scale_gain(input longint v);
      logic           neg;
      longint unsigned m, hi, lo, t, q, s, r;
      neg = (v < 0);
      m   = neg ? longint'(-v) : v;
      hi  = m >> 24;
      lo  = m & 64'hFF_FFFF;
      t   = lo * GAIN_INV_Q32;
      q   = hi * GAIN_INV_Q32 + (t >> 24);
      s   = (t & 64'hFF_FFFF) + (64'd1 << 31);
      r   = (q + (s >> 24)) >> 8;
      return neg ? -longint'(r) : longint'(r);
    endfunction

    // One plane turn: fold to within a quarter turn, run the CORDIC stages, then
    // compensate the gain. A zero angle leaves the pair untouched.
    function void turn_plane(inout longint u, inout longint v, input int ang);
      longint a, p, q, dp, dq;
      if (ang == 0) return;
      a = longint'(ang) * 65536;
      p = u;
      q = v;
      if (a > QUARTER_Q31) begin
        a = a - HALF_Q31;
        p = -p;
        q = -q;
      end else if (a < -QUARTER_Q31) begin
        a = a + HALF_Q31;
        p = -p;
        q = -q;
      end
      for (int i = 0; i < TURN_STEPS; i++) begin
        dp = q >>> i;
        dq = p >>> i;
        if (a >= 0) begin
          p = p - dp;
          q = q + dq;
          a = a - ATAN_Q31[i];
        end else begin
          p = p + dp;
          q = q - dq;
          a = a + ATAN_Q31[i];
        end
      end
      u = scale_gain(p);
      v = scale_gain(q);
    endfunction

    // Round to nearest with ties away from zero, then saturate to the coordinate range.
    function logic [COORD_BITS-1:0] round_coord(input longint v, inout logic clip);
      longint unsigned m;
      longint          r;
      m = (v < 0) ? longint'(-v) : v;
      r = longint'((m + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC);
      if (v < 0) r = -r;
      if (r > COORD_MAX) begin
        r    = COORD_MAX;
        clip = 1'b1;
      end else if (r < COORD_MIN) begin
        r    = COORD_MIN;
        clip = 1'b1;
      end
      return r[COORD_BITS-1:0];
    endfunction

    function void note_point(input logic signed [COORD_BITS-1:0] px,
                             input logic signed [COORD_BITS-1:0] py,
                             input logic signed [COORD_BITS-1:0] pz);
      longint         wx, wy, wz;
      int             ax, ay, az;
      logic           clip;
      rotated_point_t res;
      wx = longint'(px) * 65536;
      wy = longint'(py) * 65536;
      wz = longint'(pz) * 65536;
      ax = int'($signed(ang_x));
      ay = int'($signed(ang_y));
      az = int'($signed(ang_z));
      // The indirect frame turns every angle the other way; minus -32768 is a half turn.
      if (!right_hand) begin
        ax = -ax;
        ay = -ay;
        az = -az;
      end
      turn_plane(wy, wz, ax);
      turn_plane(wz, wx, ay);
      turn_plane(wx, wy, az);
      clip        = 1'b0;
      res.x       = round_coord(wx, clip);
      res.y       = round_coord(wy, clip);
      res.z       = round_coord(wz, clip);
      res.clipped = clip;
      pending.push_back(res);
      noted++;
    endfunction

    function void check_point(input logic signed [COORD_BITS-1:0] gx,
                              input logic signed [COORD_BITS-1:0] gy,
                              input logic signed [COORD_BITS-1:0] gz,
                              input logic                         gc);
      rotated_point_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Result word with nothing expected: (%0d, %0d, %0d) clipped %b",
                   gx, gy, gz, gc);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (gx !== want.x || gy !== want.y || gz !== want.z || gc !== want.clipped) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Mismatch %0d: want (%0d, %0d, %0d) clip %b, got (%0d, %0d, %0d) clip %b",
                   checked, want.x, want.y, want.z, want.clipped, gx, gy, gz, gc);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic signed [COORD_BITS-1:0]  pos_x_i;
  logic signed [COORD_BITS-1:0]  pos_y_i;
  logic signed [COORD_BITS-1:0]  pos_z_i;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i;
  logic [CFG_DATA_BITS-1:0]      cfg_data_i;
  logic                          done_o;
  logic signed [COORD_BITS-1:0]  new_x_o;
  logic signed [COORD_BITS-1:0]  new_y_o;
  logic signed [COORD_BITS-1:0]  new_z_o;
  logic                          clipped_o;

  rotation_scoreboard sb;
  int unsigned        settings;

  point_rotation_three_axis #(
    .COORD_BITS      (COORD_BITS),
    .ROTATION_STAGES (ROTATION_STAGES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .new_x_o     (new_x_o),
    .new_y_o     (new_y_o),
    .new_z_o     (new_z_o),
    .clipped_o   (clipped_o)
  );

  // Clock starts low so that the first rising edge comes after the inputs are set.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Monitor. Inputs change only through nonblocking assignments at the rising edge, so at
  // each edge this block sees the values of the cycle that the edge ends: a register write,
  // an accepted point word and a result word are all taken from that cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (start_i && !busy_o) sb.note_point(pos_x_i, pos_y_i, pos_z_i);
      if (done_o) sb.check_point(new_x_o, new_y_o, new_z_o, clipped_o);
    end
  end

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinates lean toward the range ends now and then so saturation gets exercised.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return COORD_BITS'(COORD_MAX);
      1:       return COORD_BITS'(COORD_MIN);
      2:       return '0;
      3:       return COORD_BITS'(-1);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Angles hit zero, the quarter-turn fold boundary and the half-turn ends on purpose.
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 2) != 0) return 16'($urandom);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return 16'h4000;
      4:       return 16'h4001;
      5:       return 16'hC000;
      6:       return 16'hBFFF;
      7:       return 16'h7FFF;
      8:       return 16'h8000;
      default: return 16'h2000;
    endcase
  endfunction

  // Writes one register word. Valid drops for a cycle afterwards, so consecutive writes
  // never lower and raise it within the same time step.
  task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one point word and waits until the block takes it. Start stays high when the
  // next word follows at once; otherwise it drops for the length of the gap.
  task automatic send_point(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                            input logic [COORD_BITS-1:0] pz, input int unsigned gap);
    start_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    do @(posedge clk_i); while (busy_o);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering points and waits until every expected result word has come back,
  // with a bound so that a silent block cannot hang the run. The tail covers the
  // pipeline depth at the very end.
  task automatic settle(input int unsigned tail);
    int unsigned waited;
    start_i <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (tail) @(posedge clk_i);
  endtask

  initial begin
    int unsigned items_left;
    int unsigned phase_len;
    int unsigned idle_phase;
    sb          = new();
    settings    = 1;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    pos_z_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ANGLE_X;
    cfg_data_i  = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: all angles zero, so every plane passes through exactly.
    send_point(16'h0000, 16'h0000, 16'h0000, 0);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_point(16'h8000, 16'h8000, 16'h8000, 2);
    send_point(16'h7FFF, 16'h8000, 16'h0001, 0);
    settle(0);

    // Eighth and quarter turns; x stays exact through the zero turn about x.
    program_reg(REG_ANGLE_X, 16'h0000);
    program_reg(REG_ANGLE_Y, 16'hE000);
    program_reg(REG_ANGLE_Z, 16'h4000);
    settings++;
    send_point(16'h7FFF, 16'h7FFF, 16'h0000, 0);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 0);
    send_point(16'h0001, 16'hFFFF, 16'h0001, 1);
    send_point(16'h1234, 16'hEDCB, 16'h0F0F, 0);
    settle(0);

    // Indirect frame with the half-turn ends and an angle just past the quarter turn.
    // An index outside the register list must leave everything as it was.
    program_reg(REG_ANGLE_X, 16'h8000);
    program_reg(REG_ANGLE_Y, 16'h7FFF);
    program_reg(REG_ANGLE_Z, 16'h4001);
    program_reg(REG_RIGHT_HANDED, 16'hFFFE);
    program_reg(CFG_IDX_BITS'(int'(REG_RIGHT_HANDED) + 1), 16'hFFFF);
    settings++;
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 0);
    send_point(16'h8000, 16'h8000, 16'h8000, 0);
    send_point(16'h0000, 16'h7FFF, 16'h0000, 0);
    send_point(16'h4000, 16'hC000, 16'h2000, 0);
    settle(0);

    // Eighth turns about x and z, just past a quarter turn about y; full-scale points saturate.
    program_reg(REG_ANGLE_X, 16'h2000);
    program_reg(REG_ANGLE_Y, 16'hBFFF);
    program_reg(REG_ANGLE_Z, 16'h2000);
    program_reg(REG_RIGHT_HANDED, 16'h0001);
    settings++;
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_point(16'h8000, 16'h8000, 16'h8000, 0);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 0);
    send_point(16'h8000, 16'h7FFF, 16'h0000, 0);
    send_point(16'hFFFF, 16'h0001, 16'hFFFF, 0);
    settle(0);

    // Random part: phases of random length, each with a fresh random setting, written
    // only once the previous phase has fully drained. Half the phases run without idling.
    items_left = RANDOM_ITEMS;
    while (items_left > 0) begin
      phase_len = $urandom_range(40, 120);
      if (phase_len > items_left) phase_len = items_left;
      if ($urandom_range(0, 3) != 0) program_reg(REG_ANGLE_X, pick_angle());
      if ($urandom_range(0, 3) != 0) program_reg(REG_ANGLE_Y, pick_angle());
      if ($urandom_range(0, 3) != 0) program_reg(REG_ANGLE_Z, pick_angle());
      if ($urandom_range(0, 2) != 0) program_reg(REG_RIGHT_HANDED, CFG_DATA_BITS'($urandom));
      if ($urandom_range(0, 7) == 0)
        program_reg(CFG_IDX_BITS'(int'(REG_RIGHT_HANDED) + 1 + int'($urandom_range(0, 3))),
                    CFG_DATA_BITS'($urandom));
      settings++;
      idle_phase = $urandom_range(0, 1);
      repeat (phase_len)
        send_point(pick_coord(), pick_coord(), pick_coord(), idle_phase ? pick_gap() : 0);
      items_left = items_left - phase_len;
      settle(0);
    end

    settle(LATENCY + 16);

    $display("Rotated %0d points under %0d angle settings, both frames, with idle gaps.",
             sb.noted, settings);
    $display("Compared %0d result words; %0d errors, %0d still expected.",
             sb.checked, sb.errors, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a block that stops answering.
  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d result words outstanding.", sb.pending.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
